// ----- rtl/ssh_df_pkg.sv -----
// ----------------------------------------------------------------------------
// ssh_df_pkg
// Shared types, codes and constants of the binary packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package ssh_df_pkg;

  localparam int unsigned DATA_W       = 8;
  localparam int unsigned LEN_W        = 32;
  localparam int unsigned PAY_LEN_W    = 20;
  localparam int unsigned SEQ_W        = 32;
  localparam int unsigned MAC_W        = 7;
  localparam int unsigned BSL_W        = 3;
  localparam int unsigned TRAIL_W      = 9;
  localparam int unsigned HCNT_W       = 3;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 20;

  localparam logic [HCNT_W-1:0]    LEN_BYTES      = 3'd4;
  localparam logic [LEN_W-1:0]     MIN_PACKET_LEN = 32'd12;
  localparam logic [DATA_W-1:0]    MIN_PADDING    = 8'd4;

  localparam logic [BSL_W-1:0]      RST_BLOCK_SIZE_LOG2 = 3'd3;
  localparam logic [MAC_W-1:0]      RST_MAC_LENGTH      = 7'd0;
  localparam logic [PAY_LEN_W-1:0]  RST_MAX_PACKET_LEN  = 20'd49152;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_SIZE_LOG2 = 2'd0,
    CFG_MAC_LENGTH      = 2'd1,
    CFG_MAX_PACKET_LEN  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_PADDING   = 2'd0,
    ERR_LENGTH    = 2'd1,
    ERR_TOO_LARGE = 2'd2
  } err_t;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_PAYLOAD = 4'b0010,
    PH_TRAILER = 4'b0100,
    PH_ERROR   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [BSL_W-1:0]     block_size_log2;
    logic [MAC_W-1:0]     mac_length;
    logic [PAY_LEN_W-1:0] max_packet_length;
  } cfg_t;

  typedef struct packed {
    logic                 ok;
    err_t                 code;
    logic [PAY_LEN_W-1:0] payload_len;
    logic [TRAIL_W-1:0]   trailer_len;
  } hdr_chk_t;

  typedef struct packed {
    kind_t                kind;
    logic [DATA_W-1:0]    payload_byte;
    logic                 last_payload;
    logic [SEQ_W-1:0]     packet_seqno;
    logic [PAY_LEN_W-1:0] payload_length;
    err_t                 error_code;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/ssh_df_cfg.sv -----
// ----------------------------------------------------------------------------
// ssh_df_cfg
// Configuration register file: block size, MAC length, packet length limit.
// ----------------------------------------------------------------------------
`default_nettype none

module ssh_df_cfg (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [ssh_df_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ssh_df_pkg::CFG_DATA_W-1:0]    cfg_data,
  output ssh_df_pkg::cfg_t                          cfg
);

  ssh_df_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_size_log2   <= ssh_df_pkg::RST_BLOCK_SIZE_LOG2;
      cfg_r.mac_length        <= ssh_df_pkg::RST_MAC_LENGTH;
      cfg_r.max_packet_length <= ssh_df_pkg::RST_MAX_PACKET_LEN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ssh_df_pkg::CFG_BLOCK_SIZE_LOG2:
          cfg_r.block_size_log2 <= cfg_data[ssh_df_pkg::BSL_W-1:0];
        ssh_df_pkg::CFG_MAC_LENGTH:
          cfg_r.mac_length <= cfg_data[ssh_df_pkg::MAC_W-1:0];
        ssh_df_pkg::CFG_MAX_PACKET_LEN:
          cfg_r.max_packet_length <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ssh_df_hdr_chk.sv -----
// ----------------------------------------------------------------------------
// ssh_df_hdr_chk
// Header checks on packet length and padding length, plus derived counts.
// ----------------------------------------------------------------------------
`default_nettype none

module ssh_df_hdr_chk (
  input  wire logic [ssh_df_pkg::LEN_W-1:0]   packet_len,
  input  wire logic [ssh_df_pkg::DATA_W-1:0]  pad_len,
  input  wire ssh_df_pkg::cfg_t               cfg,
  output ssh_df_pkg::hdr_chk_t                chk
);

  logic [4:0]                         bs_mask;
  logic [ssh_df_pkg::LEN_W-1:0]       min_bs_len;
  logic [4:0]                         len_low;
  logic                               bad_pad;
  logic                               bad_len;
  logic                               too_large;
  logic [ssh_df_pkg::PAY_LEN_W:0]     total_len;
  logic [ssh_df_pkg::PAY_LEN_W-1:0]   pay_len;

  always_comb begin
    case (cfg.block_size_log2) inside
      3'd0, 3'd1, 3'd2, 3'd3: begin
        bs_mask    = 5'h07;
        min_bs_len = 32'd4;
      end
      3'd4: begin
        bs_mask    = 5'h0f;
        min_bs_len = 32'd12;
      end
      default: begin
        bs_mask    = 5'h1f;
        min_bs_len = 32'd28;
      end
    endcase
  end

  assign len_low = packet_len[4:0] + 5'd4;

  assign bad_pad = (pad_len < ssh_df_pkg::MIN_PADDING) ||
                   ({24'd0, pad_len} >= packet_len);

  assign bad_len = (packet_len < ssh_df_pkg::MIN_PACKET_LEN) ||
                   (packet_len < min_bs_len) ||
                   ((len_low & bs_mask) != 5'd0);

  // only matters when the length fits below the limit, so 21 bits suffice
  assign total_len = {1'b0, packet_len[ssh_df_pkg::PAY_LEN_W-1:0]} - 21'd1 +
                     {14'd0, cfg.mac_length};

  assign too_large = (packet_len > {12'd0, cfg.max_packet_length}) ||
                     (total_len > {1'b0, cfg.max_packet_length});

  assign pay_len = packet_len[ssh_df_pkg::PAY_LEN_W-1:0] - 20'd1 - {12'd0, pad_len};

  always_comb begin
    chk.ok          = !(bad_pad || bad_len || too_large);
    chk.payload_len = pay_len;
    chk.trailer_len = {1'b0, pad_len} + {2'd0, cfg.mac_length};
    if (bad_pad) begin
      chk.code = ssh_df_pkg::ERR_PADDING;
    end else if (bad_len) begin
      chk.code = ssh_df_pkg::ERR_LENGTH;
    end else begin
      chk.code = ssh_df_pkg::ERR_TOO_LARGE;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ssh_df_core.sv -----
// ----------------------------------------------------------------------------
// ssh_df_core
// Packet phase tracking, byte counters and the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ssh_df_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               fire,
  input  wire logic [ssh_df_pkg::DATA_W-1:0]      data_byte,
  input  wire ssh_df_pkg::cfg_t                   cfg,
  output logic                                    out_ready,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output ssh_df_pkg::result_t                     result
);

  ssh_df_pkg::phase_t                  phase_r, phase_nxt;
  logic [ssh_df_pkg::HCNT_W-1:0]       hdr_cnt_r, hdr_cnt_nxt;
  logic [ssh_df_pkg::LEN_W-1:0]        pkt_len_r, pkt_len_nxt;
  logic [ssh_df_pkg::PAY_LEN_W-1:0]    bytes_left_r, bytes_left_nxt;
  logic [ssh_df_pkg::TRAIL_W-1:0]      trail_len_r, trail_len_nxt;
  logic [ssh_df_pkg::PAY_LEN_W-1:0]    pay_len_r, pay_len_nxt;
  logic [ssh_df_pkg::SEQ_W-1:0]        seq_r, seq_nxt;
  logic                                out_valid_r;
  ssh_df_pkg::result_t                 result_r, result_nxt;
  logic                                emit;
  logic [ssh_df_pkg::PAY_LEN_W-1:0]    bl_dec;
  ssh_df_pkg::hdr_chk_t                chk;

  ssh_df_hdr_chk u_hdr_chk (
    .packet_len (pkt_len_r),
    .pad_len    (data_byte),
    .cfg        (cfg),
    .chk        (chk)
  );

  assign out_ready = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign result    = result_r;
  assign bl_dec    = bytes_left_r - 20'd1;

  always_comb begin
    phase_nxt      = phase_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    pkt_len_nxt    = pkt_len_r;
    bytes_left_nxt = bytes_left_r;
    trail_len_nxt  = trail_len_r;
    pay_len_nxt    = pay_len_r;
    seq_nxt        = seq_r;
    emit           = 1'b0;
    result_nxt     = '0;
    unique case (phase_r)
      ssh_df_pkg::PH_HEADER: begin
        if (hdr_cnt_r < ssh_df_pkg::LEN_BYTES) begin
          pkt_len_nxt = {pkt_len_r[ssh_df_pkg::LEN_W-9:0], data_byte};
          hdr_cnt_nxt = hdr_cnt_r + 3'd1;
        end else begin
          hdr_cnt_nxt = '0;
          if (!chk.ok) begin
            phase_nxt             = ssh_df_pkg::PH_ERROR;
            emit                  = 1'b1;
            result_nxt.kind       = ssh_df_pkg::KIND_ERROR;
            result_nxt.error_code = chk.code;
          end else begin
            trail_len_nxt = chk.trailer_len;
            pay_len_nxt   = chk.payload_len;
            if (chk.payload_len != '0) begin
              phase_nxt      = ssh_df_pkg::PH_PAYLOAD;
              bytes_left_nxt = chk.payload_len;
            end else begin
              phase_nxt      = ssh_df_pkg::PH_TRAILER;
              bytes_left_nxt = {11'd0, chk.trailer_len};
            end
          end
        end
      end
      ssh_df_pkg::PH_PAYLOAD: begin
        emit                    = 1'b1;
        result_nxt.kind         = ssh_df_pkg::KIND_PAYLOAD;
        result_nxt.payload_byte = data_byte;
        if (bl_dec == '0) begin
          result_nxt.last_payload = 1'b1;
          phase_nxt               = ssh_df_pkg::PH_TRAILER;
          bytes_left_nxt          = {11'd0, trail_len_r};
        end else begin
          bytes_left_nxt = bl_dec;
        end
      end
      ssh_df_pkg::PH_TRAILER: begin
        bytes_left_nxt = bl_dec;
        if (bl_dec == '0) begin
          emit                      = 1'b1;
          result_nxt.kind           = ssh_df_pkg::KIND_DONE;
          result_nxt.packet_seqno   = seq_r;
          result_nxt.payload_length = pay_len_r;
          seq_nxt                   = seq_r + 32'd1;
          phase_nxt                 = ssh_df_pkg::PH_HEADER;
          hdr_cnt_nxt               = '0;
        end
      end
      ssh_df_pkg::PH_ERROR: begin
      end
      default: begin
        phase_nxt = ssh_df_pkg::PH_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ssh_df_pkg::PH_HEADER;
      hdr_cnt_r    <= '0;
      pkt_len_r    <= '0;
      bytes_left_r <= '0;
      trail_len_r  <= '0;
      pay_len_r    <= '0;
      seq_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (fire) begin
        phase_r      <= phase_nxt;
        hdr_cnt_r    <= hdr_cnt_nxt;
        pkt_len_r    <= pkt_len_nxt;
        bytes_left_r <= bytes_left_nxt;
        trail_len_r  <= trail_len_nxt;
        pay_len_r    <= pay_len_nxt;
        seq_r        <= seq_nxt;
      end
      if (out_ready) begin
        out_valid_r <= fire && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      result_r <= result_nxt;
    end
  end

  a_error_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && phase_r == ssh_df_pkg::PH_ERROR) |=> !out_valid_r)
    else $error("result produced in error phase");

  a_hdr_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_cnt_r <= ssh_df_pkg::LEN_BYTES)
    else $error("header byte count out of range");

  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ssh_df_pkg::PH_PAYLOAD || phase_r == ssh_df_pkg::PH_TRAILER)
      |-> bytes_left_r != '0)
    else $error("byte counter empty inside packet body");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && result_r.kind == ssh_df_pkg::KIND_ERROR)
      |-> phase_r == ssh_df_pkg::PH_ERROR)
    else $error("error result without error phase");

  a_done_header: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && result_r.kind == ssh_df_pkg::KIND_DONE)
      |-> (phase_r == ssh_df_pkg::PH_HEADER && hdr_cnt_r == '0))
    else $error("packet finished but not back at header start");

endmodule

`default_nettype wire

// ----- rtl/secure_shell_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// secure_shell_packet_deframer
// Byte-stream deframer for binary packets: header check, payload pass-through.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one plaintext byte per request (in_valid / in_stall).
//   out_*  : at most one result per byte: a payload byte (kind 0, last flag on
//            the final one), packet finished (kind 1, seqno and payload
//            length), or protocol error (kind 2, error code).
//   cfg_*  : register writes (index, data), always ready; write only while
//            idle. Settings are sampled on each packet's fifth header byte.
//   Throughput: one byte per cycle, limited only by out_stall.
//   Path:    a byte taken is held in the input register; its result is
//            registered in the output register when the step stage fires.
//   Reset: synchronous, active low; phase back to header, sequence number
//            zero, registers to defaults. After an error every byte is
//            consumed silently until reset.
//   Stall: a held result stops the step stage; the input register then holds
//            and in_stall rises in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module secure_shell_packet_deframer (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [ssh_df_pkg::DATA_W-1:0]       in_data_byte,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [1:0]                               out_kind,
  output logic [ssh_df_pkg::DATA_W-1:0]            out_payload_byte,
  output logic                                     out_last_payload,
  output logic [ssh_df_pkg::SEQ_W-1:0]             out_packet_seqno,
  output logic [ssh_df_pkg::PAY_LEN_W-1:0]         out_payload_length,
  output logic [1:0]                               out_error_code,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [ssh_df_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ssh_df_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic                            s1_valid_r;
  logic [ssh_df_pkg::DATA_W-1:0]   s1_data_r;
  logic                            out_ready;
  logic                            fire;
  ssh_df_pkg::cfg_t                cfg;
  ssh_df_pkg::result_t             result;

  assign fire     = s1_valid_r && out_ready;
  assign in_stall = s1_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_data_r <= in_data_byte;
    end
  end

  ssh_df_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ssh_df_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .data_byte (s1_data_r),
    .cfg       (cfg),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  assign out_kind           = result.kind;
  assign out_payload_byte   = result.payload_byte;
  assign out_last_payload   = result.last_payload;
  assign out_packet_seqno   = result.packet_seqno;
  assign out_payload_length = result.payload_length;
  assign out_error_code     = result.error_code;

endmodule

`default_nettype wire

// ----- tb/sv/secure_shell_packet_deframer_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// secure_shell_packet_deframer_checker
// Watches the byte, result and register channels of the deframer. Tracks the
// register settings and the packet framing state of its own, predicts the
// result of every accepted byte and compares each delivered result, in order,
// against the oldest prediction.
// ----------------------------------------------------------------------------
module secure_shell_packet_deframer_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [ssh_df_pkg::DATA_W-1:0]       in_data_byte,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [1:0]                          out_kind,
  input  logic [ssh_df_pkg::DATA_W-1:0]       out_payload_byte,
  input  logic                                out_last_payload,
  input  logic [ssh_df_pkg::SEQ_W-1:0]        out_packet_seqno,
  input  logic [ssh_df_pkg::PAY_LEN_W-1:0]    out_payload_length,
  input  logic [1:0]                          out_error_code,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [ssh_df_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ssh_df_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                  fail_count,
  output int                                  outstanding
);
  import ssh_df_pkg::*;

  phase_t      ph;
  logic [2:0]  hdr_cnt;
  logic [31:0] pkt_len;
  logic [7:0]  pad;
  logic [20:0] remain;
  logic [31:0] seqno;
  logic [6:0]  pkt_mac;
  logic [2:0]  reg_bsl;
  logic [6:0]  reg_mac;
  logic [19:0] reg_max;
  result_t     awaited_results[$];
  int          mismatches = 0;

  // one plaintext byte through the framing state; returns 1 when a result is due
  function automatic logic deframe_byte(input logic [7:0] b, output result_t r);
    logic [2:0]  lg;
    logic [31:0] bs;
    logic [31:0] body;
    logic        bad;
    r = '0;
    deframe_byte = 1'b0;
    case (ph)
      PH_HEADER: begin
        if (hdr_cnt < LEN_BYTES) begin
          pkt_len = {pkt_len[23:0], b};
          hdr_cnt = hdr_cnt + 3'd1;
        end else begin
          pad = b;
          hdr_cnt = '0;
          lg = (reg_bsl < 3'd3) ? 3'd3 : (reg_bsl > 3'd5) ? 3'd5 : reg_bsl;
          bs = 32'd1 << lg;
          bad = 1'b1;
          if (pad < MIN_PADDING || {24'd0, pad} >= pkt_len) begin
            r.error_code = ERR_PADDING;
          end else if (pkt_len < MIN_PACKET_LEN || pkt_len < bs - 32'd4 ||
                       ((pkt_len + 32'd4) & (bs - 32'd1)) != 32'd0) begin
            r.error_code = ERR_LENGTH;
          end else if (pkt_len > {12'd0, reg_max} ||
                       pkt_len - 32'd1 + {25'd0, reg_mac} > {12'd0, reg_max}) begin
            r.error_code = ERR_TOO_LARGE;
          end else begin
            bad = 1'b0;
          end
          if (bad) begin
            ph = PH_ERROR;
            r.kind = KIND_ERROR;
            deframe_byte = 1'b1;
          end else begin
            pkt_mac = reg_mac;
            body = pkt_len - 32'd1 - {24'd0, pad};
            if (body != 32'd0) begin
              ph = PH_PAYLOAD;
              remain = body[20:0];
            end else begin
              ph = PH_TRAILER;
              remain = {13'd0, pad} + {14'd0, pkt_mac};
            end
          end
        end
      end
      PH_PAYLOAD: begin
        r.kind = KIND_PAYLOAD;
        r.payload_byte = b;
        if (remain != 21'd0) remain = remain - 21'd1;
        if (remain == 21'd0) begin
          r.last_payload = 1'b1;
          ph = PH_TRAILER;
          remain = {13'd0, pad} + {14'd0, pkt_mac};
        end
        deframe_byte = 1'b1;
      end
      PH_TRAILER: begin
        if (remain != 21'd0) remain = remain - 21'd1;
        if (remain == 21'd0) begin
          body = pkt_len - 32'd1 - {24'd0, pad};
          r.kind = KIND_DONE;
          r.packet_seqno = seqno;
          r.payload_length = body[19:0];
          seqno = seqno + 32'd1;
          ph = PH_HEADER;
          hdr_cnt = '0;
          deframe_byte = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin : monitor
    result_t want;
    result_t got;
    if (!rst_n) begin
      ph = PH_HEADER;
      hdr_cnt = '0;
      pkt_len = '0;
      pad = '0;
      remain = '0;
      seqno = '0;
      pkt_mac = '0;
      reg_bsl = RST_BLOCK_SIZE_LOG2;
      reg_mac = RST_MAC_LENGTH;
      reg_max = RST_MAX_PACKET_LEN;
      awaited_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = result_t'({out_kind, out_payload_byte, out_last_payload, out_packet_seqno,
                         out_payload_length, out_error_code});
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result kind %0d byte %h last %b seq %0d len %0d err %0d",
                     $realtime, got.kind, got.payload_byte, got.last_payload,
                     got.packet_seqno, got.payload_length, got.error_code);
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: result mismatch (exp/got) kind %0d/%0d byte %h/%h last %b/%b ",
                        "seq %0d/%0d len %0d/%0d err %0d/%0d"},
                       $realtime, want.kind, got.kind, want.payload_byte, got.payload_byte,
                       want.last_payload, got.last_payload, want.packet_seqno,
                       got.packet_seqno, want.payload_length, got.payload_length,
                       want.error_code, got.error_code);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_BLOCK_SIZE_LOG2: reg_bsl = cfg_data[2:0];
          CFG_MAC_LENGTH:      reg_mac = cfg_data[6:0];
          CFG_MAX_PACKET_LEN:  reg_max = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (deframe_byte(in_data_byte, want)) awaited_results.push_back(want);
      end
    end
    outstanding <= awaited_results.size();
    fail_count <= mismatches;
  end

endmodule

// ----- tb/sv/secure_shell_packet_deframer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// secure_shell_packet_deframer_tb
// Feeds framed packets through the deframer under a series of register
// settings: a few hand-picked packets, then random well-formed packets with
// bursty input and a stalling receiver, and finally one malformed header
// followed by bytes that must be swallowed. Checking is done by the checker.
// ----------------------------------------------------------------------------
module secure_shell_packet_deframer_tb;
  import ssh_df_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int BYTES_PER_PHASE = 40;
  localparam int MAX_RAND_LEN    = 128;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
  typedef enum int {FILL_RANDOM, FILL_EDGES} fill_t;
  typedef enum int {
    FAULT_PAD_SHORT, FAULT_PAD_LONG, FAULT_LEN_SHORT, FAULT_LEN_ALIGN, FAULT_LEN_HUGE,
    FAULT_MAC_OVER
  } fault_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [DATA_W-1:0]     in_data_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_kind;
  logic [DATA_W-1:0]     out_payload_byte;
  logic                  out_last_payload;
  logic [SEQ_W-1:0]      out_packet_seqno;
  logic [PAY_LEN_W-1:0]  out_payload_length;
  logic [1:0]            out_error_code;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int          fail_count;
  int          outstanding;
  int          cycles = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_hold = 0;
  int          burst_left = 0;
  int          gap_max = 0;
  int          bytes_sent = 0;
  int          cur_bsl = 3;
  int          cur_mac = 0;
  int          cur_max = 49152;

  secure_shell_packet_deframer uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_payload_byte   (out_payload_byte),
    .out_last_payload   (out_last_payload),
    .out_packet_seqno   (out_packet_seqno),
    .out_payload_length (out_payload_length),
    .out_error_code     (out_error_code),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  secure_shell_packet_deframer_checker chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_payload_byte   (out_payload_byte),
    .out_last_payload   (out_last_payload),
    .out_packet_seqno   (out_packet_seqno),
    .out_payload_length (out_payload_length),
    .out_error_code     (out_error_code),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .fail_count         (fail_count),
    .outstanding        (outstanding)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[secure_shell_packet_deframer] ERROR");
      $finish;
    end
  end

  // receiver back-pressure, switching between none, light, heavy and periodic patterns
  always @(posedge clk) begin
    if (stall_hold == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_hold <= $urandom_range(50, 400);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
      default:     out_stall <= ((cycles % 7) < 3);
    endcase
  end

  task automatic push_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        in_data_byte <= 8'($urandom);
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
      case ($urandom_range(0, 3))
        0, 1: gap_max = 0;
        2:    gap_max = 3;
        default: gap_max = 12;
      endcase
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // stop sending and let every pending result drain out of the pipeline
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [19:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // unused upper data bits carry noise
  task automatic program_regs(input logic [2:0] bsl, input logic [6:0] mac,
                              input logic [19:0] maxlen);
    logic [31:0] noise;
    noise = $urandom;
    cfg_write(CFG_BLOCK_SIZE_LOG2, {noise[16:0], bsl});
    cfg_write(CFG_MAC_LENGTH, {noise[31:19], mac});
    cfg_write(CFG_MAX_PACKET_LEN, maxlen);
    cfg_valid <= 1'b0;
    cur_bsl = int'(bsl);
    cur_mac = int'(mac);
    cur_max = int'(maxlen);
  endtask

  task automatic send_header(input logic [31:0] len, input logic [7:0] pad);
    push_byte(len[31:24]);
    push_byte(len[23:16]);
    push_byte(len[15:8]);
    push_byte(len[7:0]);
    push_byte(pad);
  endtask

  task automatic send_packet(input int len, input int pad, input fill_t fill);
    send_header(32'(len), 8'(pad));
    for (int i = 0; i < len - 1 - pad; i++) begin
      if (fill == FILL_EDGES) push_byte((i % 2 == 0) ? 8'h00 : 8'hFF);
      else push_byte(8'($urandom));
    end
    for (int i = 0; i < pad + cur_mac; i++) push_byte(8'($urandom));
  endtask

  task automatic send_random_packet();
    int lg;
    int bs;
    int hi;
    int kmin;
    int kmax;
    int len;
    int pad;
    int padmax;
    lg = (cur_bsl < 3) ? 3 : (cur_bsl > 5) ? 5 : cur_bsl;
    bs = 1 << lg;
    hi = cur_max;
    if (cur_max + 1 - cur_mac < hi) hi = cur_max + 1 - cur_mac;
    if (hi > MAX_RAND_LEN) hi = MAX_RAND_LEN;
    kmin = (bs == 8) ? 2 : 1;
    kmax = (hi + 4) / bs;
    len = int'($urandom_range(kmin, kmax)) * bs - 4;
    padmax = (len - 1 > 255) ? 255 : len - 1;
    case ($urandom_range(0, 9))
      0:       pad = padmax;
      1:       pad = 4;
      default: pad = $urandom_range(4, padmax);
    endcase
    send_packet(len, pad, ($urandom_range(0, 7) == 0) ? FILL_EDGES : FILL_RANDOM);
  endtask

  task automatic run_phase(input logic [2:0] bsl, input logic [6:0] mac,
                           input logic [19:0] maxlen);
    int start;
    settle();
    program_regs(bsl, mac, maxlen);
    start = bytes_sent;
    while (bytes_sent - start < BYTES_PER_PHASE) send_random_packet();
  endtask

  initial begin
    fault_t      fault;
    logic [31:0] noise;
    int          len;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: minimum packet with 00/FF payload, then an empty payload and a longer packet
    send_packet(12, 4, FILL_EDGES);
    send_packet(12, 11, FILL_RANDOM);
    send_packet(20, 4, FILL_RANDOM);

    run_phase(3'd4, 7'd20, 20'd49152);
    run_phase(3'd5, 7'd64, 20'd1048575);
    run_phase(3'd0, 7'd5, 20'd16);
    run_phase(3'd7, 7'd127, 20'd1048575);
    run_phase(3'd3, 7'd0, 20'd300);
    run_phase(3'd6, 7'($urandom_range(0, 127)), 20'($urandom_range(420, 1048575)));
    run_phase(3'd2, 7'($urandom_range(0, 127)), 20'($urandom_range(200, 5000)));
    run_phase(3'd1, 7'($urandom_range(0, 64)), 20'($urandom_range(80, 1000)));

    // one malformed header; the block must then swallow everything silently
    settle();
    program_regs(3'd3, 7'd64, 20'd200);
    send_random_packet();
    fault = fault_t'($urandom_range(0, 5));
    noise = $urandom;
    case (fault)
      FAULT_PAD_SHORT: send_header(32'd12, 8'($urandom_range(0, 3)));
      FAULT_PAD_LONG:  send_header(32'd12, 8'($urandom_range(12, 255)));
      FAULT_LEN_SHORT: send_header(32'($urandom_range(5, 11)), 8'd4);
      FAULT_LEN_ALIGN: begin
        len = int'($urandom_range(2, 20)) * 8 - 4 + int'($urandom_range(1, 7));
        send_header(32'(len), 8'd4);
      end
      FAULT_LEN_HUGE:  send_header({1'b1, noise[27:0], 3'b100}, 8'd4);
      default: begin
        len = int'($urandom_range(18, 25)) * 8 - 4;
        send_header(32'(len), 8'($urandom_range(4, 100)));
      end
    endcase
    repeat ($urandom_range(10, 30)) push_byte(8'($urandom));
    settle();

    if (fail_count == 0) begin
      $display("[secure_shell_packet_deframer] OK");
    end else begin
      $display("[secure_shell_packet_deframer] ERROR");
    end
    $finish;
  end

endmodule
